// ----- hdl/murmur2_key_hash_defines.svh -----
// Assertion macros shared by the hash block's checker.
// No dependencies; include by bare file name.
`ifndef MURMUR2_KEY_HASH_DEFINES_SVH
`define MURMUR2_KEY_HASH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define MKH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define MKH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/mkh_pkg.sv -----
// Shared types, constants and a helper function of the key hash block.
// No dependencies.
package mkh_pkg;

    localparam int KEY_LENGTH_BITS = 16;
    localparam int HASH_BITS       = 32;
    localparam int LOG2_BITS       = 5;
    localparam int BUCKET_BITS     = 31;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_BITS  = 1;

    localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
    localparam int          WORD_SHIFT  = 24;
    localparam int          FIN_SHIFT_A = 13;
    localparam int          FIN_SHIFT_B = 15;
    localparam logic [31:0] SEED_RESET  = 32'd42;
    localparam logic [4:0]  LOG2_RESET  = 5'd9;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SEED = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOG2 = 1'b1;

    // What the back end has to do with one word.
    typedef enum logic [1:0] {
        KIND_FULL  = 2'd0,
        KIND_TAIL  = 2'd1,
        KIND_EMPTY = 2'd2
    } word_kind_t;

    // One classified word passed from front to back.
    typedef struct packed {
        logic [31:0] word;
        logic [31:0] init;
        word_kind_t  kind;
        logic        first;
        logic        last;
    } mkh_cmd_t;

    // Mask that keeps the valid tail bytes of a last word.
    function automatic logic [31:0] tail_mask(input logic [2:0] count);
        logic [31:0] mask;
        begin
            case (count)
                3'd1:    mask = 32'h0000_00ff;
                3'd2:    mask = 32'h0000_ffff;
                3'd3:    mask = 32'h00ff_ffff;
                default: mask = 32'hffff_ffff;
            endcase
            return mask;
        end
    endfunction

endpackage

// ----- hdl/mkh_queue.sv -----
// Two-entry queue of classified words between the front and back ends.
// Depends on mkh_pkg for the command type and depth.
module mkh_queue
    import mkh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  mkh_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output mkh_cmd_t head_cmd
);

    mkh_cmd_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;

    assign full      = (count_reg == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hdl/mkh_front.sv -----
// Front end: accepts key words, tracks key boundaries and classifies words.
// Depends on mkh_pkg for the command type and tail mask.
module mkh_front
    import mkh_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [31:0]                data_word,
    input  logic [2:0]                 byte_count,
    input  logic [KEY_LENGTH_BITS-1:0] key_length,
    input  logic                       last_item,
    input  logic [31:0]                seed,
    input  logic                       queue_full,
    output logic                       push,
    output mkh_cmd_t                   push_cmd
);

    logic inside_key_reg, inside_key_next;
    logic short_tail;

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // A last word with fewer than four bytes is a tail or an empty key end.
    assign short_tail = last_item && (byte_count < 3'd4);

    // Build the word for the back end.
    always_comb
    begin
        push_cmd.init  = seed ^ 32'(key_length);
        push_cmd.first = !inside_key_reg;
        push_cmd.last  = last_item;
        if (!short_tail)
        begin
            push_cmd.kind = KIND_FULL;
            push_cmd.word = data_word;
        end
        else if (byte_count == 3'd0)
        begin
            push_cmd.kind = KIND_EMPTY;
            push_cmd.word = data_word;
        end
        else
        begin
            push_cmd.kind = KIND_TAIL;
            push_cmd.word = data_word & tail_mask(byte_count);
        end
    end

    // Key boundary tracking.
    always_comb
    begin
        inside_key_next = inside_key_reg;
        if (push)
        begin
            inside_key_next = !last_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_key_reg <= 1'b0;
        end
        else
        begin
            inside_key_reg <= inside_key_next;
        end
    end

endmodule

// ----- hdl/mkh_back.sv -----
// Back end: runs the hash recurrence on one shared multiplier and holds the result.
// Depends on mkh_pkg for constants and the command type.
module mkh_back
    import mkh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  mkh_cmd_t               cmd,
    output logic                   pop,
    input  logic [LOG2_BITS-1:0]   bucket_count_log2,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [HASH_BITS-1:0]   hash_value,
    output logic [BUCKET_BITS-1:0] bucket_index
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MK1  = 7'b0000010,
        S_MK2  = 7'b0000100,
        S_MH   = 7'b0001000,
        S_MT   = 7'b0010000,
        S_FIN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } back_state_t;

    back_state_t            state_reg, state_next;
    logic [31:0]            h_reg, h_next;
    logic [31:0]            k_reg, k_next;
    logic [31:0]            word_reg, word_next;
    logic                   last_reg, last_next;
    logic                   out_valid_reg, out_valid_next;
    logic [HASH_BITS-1:0]   hash_reg, hash_next;
    logic [BUCKET_BITS-1:0] bucket_reg, bucket_next;
    logic [31:0]            mul_a;
    logic [31:0]            mul_p;
    logic [31:0]            final_h;
    logic [31:0]            bucket_mask;
    logic                   out_free;

    assign out_valid    = out_valid_reg;
    assign hash_value   = hash_reg;
    assign bucket_index = bucket_reg;
    assign out_free     = !out_valid_reg || !out_stall;
    assign pop          = (state_reg == S_IDLE) && cmd_valid;

    // Operand select for the shared multiplier; the product keeps the low word.
    always_comb
    begin
        case (state_reg)
            S_MK1:   mul_a = word_reg;
            S_MK2:   mul_a = k_reg ^ (k_reg >> WORD_SHIFT);
            S_MH:    mul_a = h_reg;
            S_MT:    mul_a = h_reg ^ word_reg;
            S_FIN:   mul_a = h_reg ^ (h_reg >> FIN_SHIFT_A);
            default: mul_a = h_reg;
        endcase
    end

    assign mul_p = mul_a * MIX_MUL;

    // Last finalization step and the bucket reduction.
    assign final_h     = h_reg ^ (h_reg >> FIN_SHIFT_B);
    assign bucket_mask = ~(32'hffff_ffff << bucket_count_log2);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        h_next         = h_reg;
        k_next         = k_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        hash_next      = hash_reg;
        bucket_next    = bucket_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    h_next    = cmd.first ? cmd.init : h_reg;
                    word_next = cmd.word;
                    last_next = cmd.last;
                    case (cmd.kind)
                        KIND_FULL:  state_next = S_MK1;
                        KIND_TAIL:  state_next = S_MT;
                        default:    state_next = S_FIN;
                    endcase
                end
            end
            S_MK1:
            begin
                k_next     = mul_p;
                state_next = S_MK2;
            end
            S_MK2:
            begin
                k_next     = mul_p;
                state_next = S_MH;
            end
            S_MH:
            begin
                h_next     = mul_p ^ k_reg;
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_MT:
            begin
                h_next     = mul_p;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                h_next     = mul_p;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    hash_next      = final_h;
                    bucket_next    = BUCKET_BITS'(final_h & bucket_mask);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            h_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            h_reg         <= h_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        word_reg   <= word_next;
        last_reg   <= last_next;
        hash_reg   <= hash_next;
        bucket_reg <= bucket_next;
    end

endmodule

// ----- hdl/murmur2_key_hash.sv -----
// Streaming 32-bit MurmurHash2 with bucket reduction. Keys arrive as little-endian
// 32-bit words; the first word's key_length is mixed into the seed, and the word
// flagged last_item may hold 0 to 3 tail bytes. Each key gives one result with
// hash_value and bucket_index = hash_value mod 2^bucket_count_log2. All multiplies
// by 0x5bd1e995 share one 32-bit multiplier, which sets the rate: a full word
// passes states MK1, MK2 and MH, a tail word MT, an empty end none; finalization
// then passes FIN and OUT before the result is registered. A two-word queue lets
// the input side keep taking words while the back end works or a result waits.
// Depends on mkh_pkg, mkh_front, mkh_queue and mkh_back.
module murmur2_key_hash
    import mkh_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [31:0]                data_word,
    input  logic [2:0]                 byte_count,
    input  logic [KEY_LENGTH_BITS-1:0] key_length,
    input  logic                       last_item,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [HASH_BITS-1:0]       hash_value,
    output logic [BUCKET_BITS-1:0]     bucket_index,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [31:0]                cfg_data
);

    logic [31:0]          seed_reg, seed_next;
    logic [LOG2_BITS-1:0] log2_reg, log2_next;
    logic                 q_full;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_not_empty;
    mkh_cmd_t             q_push_cmd;
    mkh_cmd_t             q_head_cmd;

    assign cfg_ready = 1'b1;

    // Configuration register writes.
    always_comb
    begin
        seed_next = seed_reg;
        log2_next = log2_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SEED: seed_next = cfg_data;
                CFG_LOG2: log2_next = cfg_data[LOG2_BITS-1:0];
                default:  seed_next = seed_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
            log2_reg <= LOG2_RESET;
        end
        else
        begin
            seed_reg <= seed_next;
            log2_reg <= log2_next;
        end
    end

    mkh_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_word  (data_word),
        .byte_count (byte_count),
        .key_length (key_length),
        .last_item  (last_item),
        .seed       (seed_reg),
        .queue_full (q_full),
        .push       (q_push),
        .push_cmd   (q_push_cmd)
    );

    mkh_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_cmd  (q_head_cmd)
    );

    mkh_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_valid         (q_not_empty),
        .cmd               (q_head_cmd),
        .pop               (q_pop),
        .bucket_count_log2 (log2_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .hash_value        (hash_value),
        .bucket_index      (bucket_index)
    );

endmodule

// ----- hdl/mkh_checker.sv -----
// Port-level checks of the key hash block, bound to the top level.
// Depends on mkh_pkg and murmur2_key_hash_defines.svh.
`include "murmur2_key_hash_defines.svh"

module mkh_checker
    import mkh_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [HASH_BITS-1:0]   hash_value,
    input logic [BUCKET_BITS-1:0] bucket_index,
    input logic                   cfg_valid,
    input logic                   cfg_ready
);

    // Index bits that are set where the hash bit is clear.
    logic [BUCKET_BITS-1:0] stray_bits;

    assign stray_bits = bucket_index & ~hash_value[BUCKET_BITS-1:0];

    // A stalled result word stays offered.
    `MKH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")

    // The bucket index only keeps bits of the hash.
    `MKH_ASSERT_NOW(a_bucket_subset, out_valid, stray_bits == '0, "bucket index not a masked hash")

    // The configuration port always takes a write.
    `MKH_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

    // A result is registered, so it cannot appear in the cycle after reset.
    `MKH_ASSERT_NOW(a_out_after_reset, !$past(rst_n), !out_valid, "result right after reset")

endmodule

bind murmur2_key_hash mkh_checker u_checker (.*);

// ----- test/testbench.sv -----
// Self-checking testbench for the streaming MurmurHash2 key hash block.
// It predicts each key's hash and bucket index and checks every result word.
// Depends on mkh_pkg and murmur2_key_hash.
`timescale 1ns / 1ps

module testbench;
    import mkh_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int END_CYCLES    = 40;

    // One expected result word.
    typedef struct {
        logic [HASH_BITS-1:0]   hash;
        logic [BUCKET_BITS-1:0] bucket;
    } hash_rec_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [31:0]                data_word = '0;
    logic [2:0]                 byte_count = '0;
    logic [KEY_LENGTH_BITS-1:0] key_length = '0;
    logic                       last_item = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [HASH_BITS-1:0]       hash_value;
    logic [BUCKET_BITS-1:0]     bucket_index;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [31:0]                cfg_data = '0;

    // Predictor state and its copy of the registers.
    logic [31:0] acc_hash = '0;
    logic        mid_key = 1'b0;
    logic [31:0] seed_reg = SEED_RESET;
    logic [4:0]  log2_reg = LOG2_RESET;

    hash_rec_t   pending_hashes[$];
    hash_rec_t   want;
    int          errors = 0;
    int          words_sent = 0;
    int          idle_cycles = 0;
    bit          steady_flow = 1'b0;
    bit          hold_results = 1'b0;

    murmur2_key_hash dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_word    (data_word),
        .byte_count   (byte_count),
        .key_length   (key_length),
        .last_item    (last_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hash_value   (hash_value),
        .bucket_index (bucket_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Low 32 bits of a product.
    function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
        return a * b;
    endfunction

    // Mixes one full four-byte word into the running hash.
    function automatic logic [31:0] fold_word(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] m;
        m = mul_lo(k, MIX_MUL);
        m = m ^ (m >> WORD_SHIFT);
        m = mul_lo(m, MIX_MUL);
        return mul_lo(h, MIX_MUL) ^ m;
    endfunction

    // Advances the predicted hash by one accepted word; a last word queues a result.
    task automatic hash_step(input logic [31:0] w, input logic [2:0] cnt,
                             input logic [KEY_LENGTH_BITS-1:0] len, input logic fin);
        logic [31:0] h;
        logic [31:0] keep;
        logic [31:0] lmask;
        hash_rec_t   rec;
        if (!mid_key)
            acc_hash = seed_reg ^ 32'(len);
        h = acc_hash;
        if (!fin)
        begin
            acc_hash = fold_word(h, w);
            mid_key = 1'b1;
        end
        else
        begin
            if (cnt >= 3'd4)
                h = fold_word(h, w);
            else if (cnt != 3'd0)
            begin
                keep = (32'd1 << (8 * cnt)) - 32'd1;
                h = mul_lo(h ^ (w & keep), MIX_MUL);
            end
            h = h ^ (h >> FIN_SHIFT_A);
            h = mul_lo(h, MIX_MUL);
            h = h ^ (h >> FIN_SHIFT_B);
            acc_hash = h;
            mid_key = 1'b0;
            lmask = (32'd1 << log2_reg) - 32'd1;
            rec.hash = h;
            rec.bucket = BUCKET_BITS'(h & lmask);
            pending_hashes.push_back(rec);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                   input logic [31:0] got_val);
        $display("mismatch on %s: expected %h, got %h", what, exp_val, got_val);
        errors++;
    endtask

    // Offers one word after a random gap and waits until it is taken.
    task automatic send_word(input logic [31:0] w, input logic [2:0] cnt,
                             input logic [KEY_LENGTH_BITS-1:0] len, input logic fin);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_word  <= w;
        byte_count <= cnt;
        key_length <= len;
        last_item  <= fin;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        hash_step(w, cnt, len, fin);
        words_sent++;
    endtask

    // Stops offering words and waits until the block has nothing left in flight.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register; only called while the block is settled.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_SEED)
            seed_reg = value;
        else if (idx == CFG_LOG2)
            log2_reg = value[4:0];
        // Wait with cfg_valid low so that a following write starts on a fresh edge.
        @(posedge clk);
    endtask

    // Random key word, with the all-zero and all-one patterns now and then.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // One key: a few full words and a last word, with a matching or arbitrary length.
    task automatic send_random_key(input int max_words);
        int n;
        int i;
        logic [2:0] tail;
        logic [2:0] cnt;
        logic [KEY_LENGTH_BITS-1:0] len;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 16) : $urandom_range(0, max_words);
        tail = ($urandom_range(0, 3) != 0) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(0, 7));
        if ($urandom_range(0, 1) == 1)
            len = KEY_LENGTH_BITS'(4 * n + ((tail > 3'd4) ? 4 : tail));
        else
            len = KEY_LENGTH_BITS'($urandom);
        for (i = 0; i < n; i++)
        begin
            cnt = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'd4;
            send_word(rand_word(), cnt, (i == 0) ? len : KEY_LENGTH_BITS'($urandom), 1'b0);
        end
        send_word(rand_word(), tail, (n == 0) ? len : KEY_LENGTH_BITS'($urandom), 1'b1);
    endtask

    // Corner keys under the reset register values.
    task automatic test_directed_keys();
        // Empty key, single tail keys whose unused bytes are all ones, and an all-zero full word.
        send_word(32'hffff_ffff, 3'd0, 16'd0, 1'b1);
        send_word(32'hffff_ffff, 3'd1, 16'd1, 1'b1);
        send_word(32'hffff_ffff, 3'd2, 16'd2, 1'b1);
        send_word(32'hffff_ffff, 3'd3, 16'd3, 1'b1);
        send_word(32'h0000_0000, 3'd4, 16'hffff, 1'b1);
        // Counts above four on a last word act as a full word.
        send_word(32'h1234_5678, 3'd5, 16'd4, 1'b1);
        send_word(32'hdead_beef, 3'd6, 16'd4, 1'b1);
        send_word(32'hffff_ffff, 3'd7, 16'hffff, 1'b1);
        // Multiword key: byte_count on middle words is ignored.
        send_word(32'hffff_ffff, 3'd0, 16'd10, 1'b0);
        send_word(32'h0000_0000, 3'd7, 16'hffff, 1'b0);
        send_word(32'ha5a5_5a5a, 3'd2, 16'd0, 1'b1);
        // Declared length far from the words that arrive.
        send_word(32'h0102_0304, 3'd4, 16'd1000, 1'b0);
        send_word(32'h0506_0708, 3'd1, 16'd7, 1'b1);
        settle_block();
    endtask

    // A seed written inside a key only applies from the next key on.
    task automatic test_seed_mid_key();
        send_word(32'hcafe_f00d, 3'd4, 16'd6, 1'b0);
        settle_block();
        write_reg(CFG_SEED, 32'h9e37_79b9);
        send_word(32'h0000_beef, 3'd2, 16'd0, 1'b1);
        send_word(32'h1111_2222, 3'd3, 16'd3, 1'b1);
        settle_block();
        write_reg(CFG_LOG2, 32'd4);
        send_word(32'h3333_4444, 3'd4, 16'd4, 1'b1);
        settle_block();
    endtask

    // Random keys under one register setting.
    task automatic test_random_phase(input logic [31:0] seed_val, input logic [4:0] log2_val,
                                     input int n_words, input bit steady);
        int start;
        settle_block();
        write_reg(CFG_SEED, seed_val);
        write_reg(CFG_LOG2, 32'(log2_val));
        steady_flow = steady;
        start = words_sent;
        while (words_sent - start < n_words)
            send_random_key(4);
        steady_flow = 1'b0;
        settle_block();
    endtask

    // The receiver holds off while words keep coming, so the input side must stall.
    task automatic test_backpressure();
        int k;
        settle_block();
        write_reg(CFG_LOG2, 32'($urandom_range(1, 30)));
        hold_results = 1'b1;
        steady_flow = 1'b1;
        for (k = 0; k < 12; k++)
            send_random_key(3);
        steady_flow = 1'b0;
        settle_block();
    endtask

    // Receiver: a random hold before each word, and a long hold on request.
    initial
    begin
        int gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            else
            begin
                gap = steady_flow ? 0 : $urandom_range(0, 5);
                if (gap > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Compares each accepted result word with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_hashes.size() == 0)
                report_mismatch("unexpected result hash", 32'd0, hash_value);
            else
            begin
                want = pending_hashes.pop_front();
                if (hash_value !== want.hash)
                    report_mismatch("hash_value", want.hash, hash_value);
                if (bucket_index !== want.bucket)
                    report_mismatch("bucket_index", 32'(want.bucket), 32'(bucket_index));
            end
        end
    end

    // Ends the run if no channel moves a word for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[murmur2_key_hash] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_keys();
        test_seed_mid_key();
        test_random_phase(32'h0000_0000, 5'd0, 230, 1'b0);
        test_random_phase(32'hffff_ffff, 5'd31, 230, 1'b0);
        test_random_phase($urandom, 5'd1, 180, 1'b1);
        test_backpressure();
        test_random_phase($urandom, 5'($urandom_range(2, 30)), 230, 1'b0);
        in_valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("[murmur2_key_hash] OK");
        else
            $display("[murmur2_key_hash] ERROR");
        $finish;
    end

endmodule
